// ===== sv/cpr_pkg.sv =====
// cpr_pkg: shared constants and types of the correlation peak ratio block
// configuration register indexes, field widths and the back-end state type
// no dependencies
package cpr_pkg;

	// configuration port
	localparam int CFG_W     = 14;
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_LENGTH    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_EXCLUDE_WIDTH = 1'b1;
	localparam logic [CFG_W-1:0] ROW_LENGTH_RST    = 14'd4096;
	localparam logic [CFG_W-1:0] EXCLUDE_WIDTH_RST = 14'd4;

	// port field widths
	localparam int CORR_W  = 32;
	localparam int INDEX_W = 16;
	localparam int RATIO_W = 32;
	localparam int FRAC_W  = 16;

	// back-end sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MOD_GO,
		ST_MOD_RUN,
		ST_PREP,
		ST_SCAN,
		ST_DIV_GO,
		ST_DIV_RUN,
		ST_OUT
	} back_state_t;

	// back-end control decoded from the state
	typedef struct packed {
		logic pop;
		logic div_start;
		logic div_mod;
		logic rd_issue;
		logic hold;
	} back_ctrl_t;

endpackage

// ===== sv/cpr_ram.sv =====
// cpr_ram: generic simple dual-port RAM, one write and one registered read port
// no dependencies
module cpr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== sv/cpr_div.sv =====
// cpr_div: restoring divider, one quotient bit per cycle
// used for the row modulo and for the peak ratio; no dependencies
module cpr_div #(
	parameter int NUM_W = 48,
	parameter int DEN_W = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quot,
	output logic [DEN_W-1:0] rem
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;

	logic [DEN_W:0]   partial;
	logic [DEN_W:0]   diff;
	logic             ge;

	// one restoring step
	always_comb begin
		partial = {rem_q, num_q[NUM_W-1]};
		diff    = partial - {1'b0, den_q};
		ge      = (partial >= {1'b0, den_q});
	end

	// step counter and completion pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(NUM_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// operands, partial remainder and quotient shifting in
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], ge};
			rem_q <= ge ? diff[DEN_W-1:0] : partial[DEN_W-1:0];
		end
	end

	assign done = done_q;
	assign quot = num_q;
	assign rem  = rem_q;

endmodule

// ===== sv/cpr_front.sv =====
// cpr_front: accepts map words, stores them and tracks the running peak
// hands each finished map to the back end as a job; depends on cpr_pkg
module cpr_front #(
	parameter int VALUE_WIDTH = 32,
	parameter int MAP_DEPTH   = 65536
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [cpr_pkg::CORR_W-1:0]       corr_value,
	input  logic                             last_item,
	input  logic                             map_hold,
	output logic                             wr_en,
	output logic [$clog2(MAP_DEPTH)-1:0]     wr_addr,
	output logic [VALUE_WIDTH-1:0]           wr_data,
	output logic                             job_push,
	output logic [VALUE_WIDTH-1:0]           job_value,
	output logic [$clog2(MAP_DEPTH)-1:0]     job_pos,
	output logic [$clog2(MAP_DEPTH+1)-1:0]   job_count,
	output logic                             job_ovf
);

	import cpr_pkg::*;

	localparam int POS_W = $clog2(MAP_DEPTH);
	localparam int CNT_W = $clog2(MAP_DEPTH + 1);

	logic [VALUE_WIDTH-1:0] best_q;
	logic [POS_W-1:0]       pos_q;
	logic [CNT_W-1:0]       count_q;
	logic                   ovf_q;

	logic                   accept;
	logic                   room;
	logic [VALUE_WIDTH-1:0] value;
	logic [VALUE_WIDTH-1:0] best_n;
	logic [POS_W-1:0]       pos_n;
	logic [CNT_W-1:0]       count_n;
	logic                   ovf_n;

	assign in_stall = map_hold;
	assign accept   = in_valid && !in_stall;
	assign value    = VALUE_WIDTH'(corr_value);
	assign room     = (count_q < CNT_W'(MAP_DEPTH));

	// peak tracking, first occurrence wins on ties
	always_comb begin
		best_n  = best_q;
		pos_n   = pos_q;
		count_n = count_q;
		ovf_n   = ovf_q;
		if (room) begin
			count_n = count_q + 1'b1;
			if (value > best_q) begin
				best_n = value;
				pos_n  = count_q[POS_W-1:0];
			end
		end else begin
			ovf_n = 1'b1;
		end
	end

	// store write
	assign wr_en   = accept && room;
	assign wr_addr = count_q[POS_W-1:0];
	assign wr_data = value;

	// job handoff on the last word
	assign job_push  = accept && last_item;
	assign job_value = best_n;
	assign job_pos   = pos_n;
	assign job_count = count_n;
	assign job_ovf   = ovf_n;

	// running map state, cleared after each map
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q  <= '0;
			pos_q   <= '0;
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (accept) begin
			if (last_item) begin
				best_q  <= '0;
				pos_q   <= '0;
				count_q <= '0;
				ovf_q   <= 1'b0;
			end else begin
				best_q  <= best_n;
				pos_q   <= pos_n;
				count_q <= count_n;
				ovf_q   <= ovf_n;
			end
		end
	end

endmodule

// ===== sv/cpr_back.sv =====
// cpr_back: job queue, row modulo, peak row rescan for the second peak and ratio divide
// depends on cpr_pkg and cpr_div
module cpr_back #(
	parameter int VALUE_WIDTH = 32,
	parameter int MAP_DEPTH   = 65536,
	parameter int ROW_MAX     = 8192
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [cpr_pkg::CFG_W-1:0]        row_length,
	input  logic [cpr_pkg::CFG_W-1:0]        exclude_width,
	input  logic                             job_push,
	input  logic [VALUE_WIDTH-1:0]           job_value,
	input  logic [$clog2(MAP_DEPTH)-1:0]     job_pos,
	input  logic [$clog2(MAP_DEPTH+1)-1:0]   job_count,
	input  logic                             job_ovf,
	output logic                             map_hold,
	output logic                             rd_en,
	output logic [$clog2(MAP_DEPTH)-1:0]     rd_addr,
	input  logic [VALUE_WIDTH-1:0]           rd_data,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [cpr_pkg::INDEX_W-1:0]      peak_index,
	output logic [cpr_pkg::RATIO_W-1:0]      peak_ratio,
	output logic                             divide_by_zero,
	output logic                             overflow
);

	import cpr_pkg::*;

	localparam int POS_W  = $clog2(MAP_DEPTH);
	localparam int CNT_W  = $clog2(MAP_DEPTH + 1);
	localparam int ROW_W  = $clog2(ROW_MAX + 1);
	localparam int JOB_W  = VALUE_WIDTH + POS_W + CNT_W + 1;
	localparam int CMP_W  = (ROW_W > CFG_W) ? ROW_W : CFG_W;
	localparam int SUM_W  = ((CNT_W > ROW_W) ? CNT_W : ROW_W) + 1;
	localparam int NUM_A  = VALUE_WIDTH + FRAC_W;
	localparam int NUM_B  = (NUM_A > POS_W) ? NUM_A : POS_W;
	localparam int NUM_W  = (NUM_B > RATIO_W) ? NUM_B : RATIO_W + 1;
	localparam int DEN_W  = (VALUE_WIDTH > ROW_W) ? VALUE_WIDTH : ROW_W;

	back_state_t state_q, state_n;
	back_ctrl_t  ctrl;

	// job queue
	logic [JOB_W-1:0] queue_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       fill_q;

	// current job
	logic [VALUE_WIDTH-1:0] best_q;
	logic [POS_W-1:0]       pos_q;
	logic [CNT_W-1:0]       count_q;
	logic                   ovf_q;
	logic [ROW_W-1:0]       rl_q;
	logic [CFG_W-1:0]       excl_q;

	// rescan state
	logic [ROW_W-1:0]       pk_q;
	logic [POS_W-1:0]       base_q;
	logic                   start_q;
	logic [ROW_W-1:0]       i_q;
	logic [VALUE_WIDTH-1:0] sv_q;
	logic                   rd_v_s1;
	logic                   first_s1;
	logic                   use_s1;

	// result register
	logic [INDEX_W-1:0]     out_index_q;
	logic [RATIO_W-1:0]     out_ratio_q;
	logic                   out_dz_q;
	logic                   out_ovf_q;

	// combinational helpers
	logic [VALUE_WIDTH-1:0] head_value;
	logic [POS_W-1:0]       head_pos;
	logic [CNT_W-1:0]       head_count;
	logic                   head_ovf;
	logic [CMP_W-1:0]       rl_wide;
	logic [ROW_W-1:0]       rl_clamp;
	logic [POS_W-1:0]       base_c;
	logic                   prep_empty;
	logic [SUM_W-1:0]       scan_addr;
	logic                   scan_more;
	logic [ROW_W-1:0]       pk_gap;
	logic [NUM_W-1:0]       div_num;
	logic [DEN_W-1:0]       div_den;
	logic                   div_done;
	logic [NUM_W-1:0]       div_quot;
	logic [DEN_W-1:0]       div_rem;
	logic [RATIO_W-1:0]     ratio_sat;

	// queue head fields
	assign {head_ovf, head_count, head_pos, head_value} = queue_q[rd_ptr_q];

	// effective row length, clamped to 2 .. ROW_MAX
	always_comb begin
		rl_wide = CMP_W'(row_length);
		if (rl_wide < CMP_W'(2)) begin
			rl_clamp = ROW_W'(2);
		end else if (rl_wide > CMP_W'(ROW_MAX)) begin
			rl_clamp = ROW_W'(ROW_MAX);
		end else begin
			rl_clamp = ROW_W'(rl_wide);
		end
	end

	// row base and empty-row check
	always_comb begin
		base_c     = pos_q - POS_W'(pk_q);
		prep_empty = (SUM_W'(base_c) + SUM_W'(pk_q == '0)) >= SUM_W'(count_q);
	end

	// scan address, end condition and distance to the peak
	always_comb begin
		scan_addr = SUM_W'(base_q) + SUM_W'(i_q);
		scan_more = (i_q < rl_q) && (scan_addr < SUM_W'(count_q));
		pk_gap    = (pk_q > i_q) ? (pk_q - i_q) : (i_q - pk_q);
	end

	// divider operand select: row modulo or peak ratio
	always_comb begin
		if (ctrl.div_mod) begin
			div_num = NUM_W'(pos_q);
			div_den = DEN_W'(rl_q);
		end else begin
			div_num = NUM_W'({best_q, FRAC_W'(0)});
			div_den = DEN_W'(sv_q);
		end
	end

	// quotient saturation to 16.16
	assign ratio_sat = (|div_quot[NUM_W-1:RATIO_W]) ? '1 : div_quot[RATIO_W-1:0];

	cpr_div #(
		.NUM_W (NUM_W),
		.DEN_W (DEN_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ctrl.div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_quot),
		.rem    (div_rem)
	);

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE:    if (fill_q != 2'd0) state_n = ST_MOD_GO;
			ST_MOD_GO:  state_n = ST_MOD_RUN;
			ST_MOD_RUN: if (div_done) state_n = ST_PREP;
			ST_PREP:    state_n = prep_empty ? ST_DIV_GO : ST_SCAN;
			ST_SCAN:    if (!scan_more) state_n = ST_DIV_GO;
			ST_DIV_GO:  state_n = (sv_q == '0) ? ST_OUT : ST_DIV_RUN;
			ST_DIV_RUN: if (div_done) state_n = ST_OUT;
			ST_OUT:     if (!out_stall) state_n = ST_IDLE;
			default:    state_n = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		ctrl = '0;
		unique case (state_q)
			ST_IDLE: begin
				ctrl.pop  = (fill_q != 2'd0);
				ctrl.hold = (fill_q != 2'd0);
			end
			ST_MOD_GO: begin
				ctrl.div_start = 1'b1;
				ctrl.div_mod   = 1'b1;
				ctrl.hold      = 1'b1;
			end
			ST_MOD_RUN: ctrl.hold = 1'b1;
			ST_PREP:    ctrl.hold = 1'b1;
			ST_SCAN: begin
				ctrl.rd_issue = scan_more;
				ctrl.hold     = 1'b1;
			end
			ST_DIV_GO: begin
				ctrl.div_start = (sv_q != '0);
				ctrl.hold      = (fill_q != 2'd0);
			end
			ST_DIV_RUN: ctrl.hold = (fill_q != 2'd0);
			ST_OUT:     ctrl.hold = (fill_q != 2'd0);
			default:    ctrl = '0;
		endcase
	end

	assign map_hold = ctrl.hold;
	assign rd_en    = ctrl.rd_issue;
	assign rd_addr  = scan_addr[POS_W-1:0];

	// state and queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
			rd_v_s1  <= 1'b0;
		end else begin
			state_q <= state_n;
			rd_v_s1 <= ctrl.rd_issue;
			if (job_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (ctrl.pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			priority if (job_push && !ctrl.pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (!job_push && ctrl.pop) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (job_push) begin
			queue_q[wr_ptr_q] <= {job_ovf, job_count, job_pos, job_value};
		end
	end

	// job, rescan and result datapath
	always_ff @(posedge clk) begin
		if (ctrl.pop) begin
			best_q  <= head_value;
			pos_q   <= head_pos;
			count_q <= head_count;
			ovf_q   <= head_ovf;
			rl_q    <= rl_clamp;
			excl_q  <= exclude_width;
		end
		if (state_q == ST_MOD_RUN && div_done) begin
			pk_q <= ROW_W'(div_rem);
		end
		if (state_q == ST_PREP) begin
			base_q  <= base_c;
			start_q <= (pk_q == '0);
			i_q     <= ROW_W'(pk_q == '0);
			sv_q    <= '0;
		end
		// issue one row read per cycle
		if (ctrl.rd_issue) begin
			i_q      <= i_q + 1'b1;
			first_s1 <= (i_q == ROW_W'(start_q));
			use_s1   <= (CMP_W'(pk_gap) >= CMP_W'(excl_q));
		end
		// fold returning read data into the second peak
		if (rd_v_s1) begin
			if (first_s1 || (use_s1 && rd_data > sv_q)) begin
				sv_q <= rd_data;
			end
		end
		if (state_q == ST_DIV_GO) begin
			out_index_q <= INDEX_W'(pos_q);
			out_ovf_q   <= ovf_q;
			if (sv_q == '0) begin
				out_ratio_q <= '1;
				out_dz_q    <= 1'b1;
			end
		end
		if (state_q == ST_DIV_RUN && div_done) begin
			out_ratio_q <= ratio_sat;
			out_dz_q    <= 1'b0;
		end
	end

	assign out_valid      = (state_q == ST_OUT);
	assign peak_index     = out_index_q;
	assign peak_ratio     = out_ratio_q;
	assign divide_by_zero = out_dz_q;
	assign overflow       = out_ovf_q;

endmodule

// ===== sv/correlation_peak_ratio.sv =====
// correlation_peak_ratio: top level, configuration registers and block wiring
// depends on cpr_pkg, cpr_ram, cpr_front, cpr_back
//
// Takes a correlation map one word per cycle while in_stall is low, stores
// it in a MAP_DEPTH-entry RAM and tracks the global peak (first occurrence
// on ties). The word marked last closes the map and queues a job for the
// back end, which finds the peak's row position with a bit-serial divider
// (NUM_W quotient bits, 48 with the default VALUE_WIDTH), rescans the peak's
// row at one RAM read per cycle (at most the clamped row_length reads), then
// divides peak by second peak on the same divider. Input words are stalled
// from the last word until the row rescan is done, and until any earlier
// result has been divided and taken; the ratio divide and the wait for the
// result to be taken overlap with the next map. The RAM needs no clearing
// after reset. Configuration must be written only while the block is idle;
// the block itself does not enforce this.
module correlation_peak_ratio #(
	parameter int VALUE_WIDTH = 32,
	parameter int MAP_DEPTH   = 65536,
	parameter int ROW_MAX     = 8192
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [cpr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [cpr_pkg::CFG_W-1:0]         cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [cpr_pkg::CORR_W-1:0]        corr_value,
	input  logic                              last_item,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [cpr_pkg::INDEX_W-1:0]       peak_index,
	output logic [cpr_pkg::RATIO_W-1:0]       peak_ratio,
	output logic                              divide_by_zero,
	output logic                              overflow
);

	import cpr_pkg::*;

	localparam int POS_W = $clog2(MAP_DEPTH);
	localparam int CNT_W = $clog2(MAP_DEPTH + 1);

	logic [CFG_W-1:0]       row_length_q;
	logic [CFG_W-1:0]       exclude_width_q;

	logic                   wr_en;
	logic [POS_W-1:0]       wr_addr;
	logic [VALUE_WIDTH-1:0] wr_data;
	logic                   rd_en;
	logic [POS_W-1:0]       rd_addr;
	logic [VALUE_WIDTH-1:0] rd_data;
	logic                   job_push;
	logic [VALUE_WIDTH-1:0] job_value;
	logic [POS_W-1:0]       job_pos;
	logic [CNT_W-1:0]       job_count;
	logic                   job_ovf;
	logic                   map_hold;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_length_q    <= ROW_LENGTH_RST;
			exclude_width_q <= EXCLUDE_WIDTH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ROW_LENGTH:    row_length_q    <= cfg_data;
				CFG_EXCLUDE_WIDTH: exclude_width_q <= cfg_data;
				default:           row_length_q    <= row_length_q;
			endcase
		end
	end

	// map store
	cpr_ram #(
		.WIDTH (VALUE_WIDTH),
		.DEPTH (MAP_DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// word intake and peak tracking
	cpr_front #(
		.VALUE_WIDTH (VALUE_WIDTH),
		.MAP_DEPTH   (MAP_DEPTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.corr_value (corr_value),
		.last_item  (last_item),
		.map_hold   (map_hold),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.job_push   (job_push),
		.job_value  (job_value),
		.job_pos    (job_pos),
		.job_count  (job_count),
		.job_ovf    (job_ovf)
	);

	// rescan, divide and result
	cpr_back #(
		.VALUE_WIDTH (VALUE_WIDTH),
		.MAP_DEPTH   (MAP_DEPTH),
		.ROW_MAX     (ROW_MAX)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.row_length     (row_length_q),
		.exclude_width  (exclude_width_q),
		.job_push       (job_push),
		.job_value      (job_value),
		.job_pos        (job_pos),
		.job_count      (job_count),
		.job_ovf        (job_ovf),
		.map_hold       (map_hold),
		.rd_en          (rd_en),
		.rd_addr        (rd_addr),
		.rd_data        (rd_data),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.peak_index     (peak_index),
		.peak_ratio     (peak_ratio),
		.divide_by_zero (divide_by_zero),
		.overflow       (overflow)
	);

endmodule

// ===== tb/correlation_peak_ratio_test.sv =====
`timescale 1ns / 1ps
// correlation_peak_ratio_test: self-checking bench for the correlation peak ratio block
// depends on cpr_pkg and correlation_peak_ratio; drives maps, predicts or lists every peak report
module correlation_peak_ratio_test;
	import cpr_pkg::*;

	localparam int MAP_DEPTH = 65536;
	localparam int ROW_MAX   = 8192;
	localparam int DIV_STEPS = 48;

	typedef struct packed {
		logic [INDEX_W-1:0] pos;
		logic [RATIO_W-1:0] ratio;
		logic               dz;
		logic               ovf;
	} peak_report_t;

	typedef struct packed {
		logic [CORR_W-1:0] value;
		logic              last;
		logic              typed;
		peak_report_t      want;
	} dir_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 in_valid;
	logic                 in_stall;
	logic [CORR_W-1:0]    corr_value;
	logic                 last_item;
	logic                 out_valid;
	logic                 out_stall;
	logic [INDEX_W-1:0]   peak_index;
	logic [RATIO_W-1:0]   peak_ratio;
	logic                 divide_by_zero;
	logic                 overflow;

	correlation_peak_ratio u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.corr_value    (corr_value),
		.last_item     (last_item),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.peak_index    (peak_index),
		.peak_ratio    (peak_ratio),
		.divide_by_zero(divide_by_zero),
		.overflow      (overflow)
	);

	// predictor state: stored map, running peak, register copies
	logic [CORR_W-1:0] map_mem [MAP_DEPTH];
	logic [CORR_W-1:0] top_value;
	int                top_pos;
	int                word_count;
	logic              map_dropped;
	int                row_cfg;
	int                excl_cfg;

	peak_report_t reports_due[$];
	dir_row_t     dir_tab[$];

	int idle_pct;
	int stall_pct;
	int rx_hold;
	int rx_gap;
	int mismatches;
	int reports_seen;
	int words_sent;
	int maps_sent;
	int settings_used;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#20_000_000;
		$display("tb: failure");
		$finish;
	end

	// row length as the block uses it
	function automatic int active_row();
		int rl;
		rl = row_cfg;
		if (rl < 2)
			rl = 2;
		if (rl > ROW_MAX)
			rl = ROW_MAX;
		return rl;
	endfunction

	// best value of the peak's row outside the exclusion window; the first scanned word always counts
	function automatic logic [CORR_W-1:0] second_peak();
		int rl, pk, base, start, i, pk_gap;
		logic [CORR_W-1:0] sv;
		rl = active_row();
		pk = top_pos % rl;
		base = top_pos - pk;
		start = (pk == 0) ? 1 : 0;
		if (base + start >= word_count)
			return '0;
		sv = map_mem[base + start];
		for (i = start + 1; i < rl; i++) begin
			if (base + i >= word_count)
				break;
			pk_gap = (pk > i) ? (pk - i) : (i - pk);
			if (pk_gap < excl_cfg)
				continue;
			if (map_mem[base + i] > sv)
				sv = map_mem[base + i];
		end
		return sv;
	endfunction

	// take one accepted word into the predictor, report on the last word
	task automatic absorb_word(input logic [CORR_W-1:0] value, input logic last,
			output logic got, output peak_report_t rep);
		logic [CORR_W-1:0] sv;
		logic [63:0] quot;
		got = 1'b0;
		rep = '0;
		if (word_count < MAP_DEPTH) begin
			map_mem[word_count] = value;
			if (value > top_value) begin
				top_value = value;
				top_pos = word_count;
			end
			word_count++;
		end else begin
			map_dropped = 1'b1;
		end
		if (last) begin
			sv = second_peak();
			rep.pos = top_pos[INDEX_W-1:0];
			rep.dz = (sv == '0);
			rep.ovf = map_dropped;
			if (rep.dz) begin
				rep.ratio = '1;
			end else begin
				quot = {16'h0, top_value, 16'h0} / {32'h0, sv};
				rep.ratio = (quot > 64'hFFFF_FFFF) ? '1 : quot[RATIO_W-1:0];
			end
			got = 1'b1;
			top_value = '0;
			top_pos = 0;
			word_count = 0;
			map_dropped = 1'b0;
		end
	endtask

	// random gap length, mostly short, a few long
	function automatic int pick_gap(int pct);
		if ($urandom_range(0, 99) >= pct)
			return 0;
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// map value by flavor: full range, small with ties, sparse, extremes
	function automatic logic [CORR_W-1:0] pick_value(int mode);
		case (mode)
			0: return $urandom;
			1: return $urandom_range(0, 7);
			2: return ($urandom_range(0, 9) < 8) ? '0 : $urandom;
			default: begin
				case ($urandom_range(0, 2))
					0: return '0;
					1: return 32'hFFFF_FFFF;
					default: return 32'hFFFF_FFFE;
				endcase
			end
		endcase
	endfunction

	function automatic void add_row(logic [CORR_W-1:0] value, logic last, logic typed,
			logic [INDEX_W-1:0] pos, logic [RATIO_W-1:0] ratio, logic dz, logic ovf);
		dir_row_t r;
		r.value = value;
		r.last = last;
		r.typed = typed;
		r.want = '{pos: pos, ratio: ratio, dz: dz, ovf: ovf};
		dir_tab.push_back(r);
	endfunction

	// send one word, wait for it to be taken, then predict
	task automatic push_word(input logic [CORR_W-1:0] value, input logic last,
			input logic typed, input peak_report_t typed_rep);
		int gap;
		logic got;
		peak_report_t rep;
		gap = pick_gap(idle_pct);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		corr_value <= value;
		last_item <= last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		absorb_word(value, last, got, rep);
		if (got) begin
			reports_due.push_back(typed ? typed_rep : rep);
			maps_sent++;
		end
		words_sent++;
	endtask

	// wait until every report is in and the back end has drained
	task automatic settle();
		in_valid <= 1'b0;
		while (reports_due.size() != 0)
			@(posedge clk);
		repeat (2 * DIV_STEPS + active_row() + 16) @(posedge clk);
	endtask

	// write both registers, back to back
	task automatic load_settings(input int row, input int excl);
		cfg_we <= 1'b1;
		cfg_index <= CFG_ROW_LENGTH;
		cfg_data <= row[CFG_W-1:0];
		@(posedge clk);
		cfg_index <= CFG_EXCLUDE_WIDTH;
		cfg_data <= excl[CFG_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		row_cfg = row & 16'h3FFF;
		excl_cfg = excl & 16'h3FFF;
		settings_used++;
	endtask

	function automatic void cmp_field(string name, longint unsigned want,
			longint unsigned got);
		if (want != got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("report %0d: %s expected %h, got %h", reports_seen, name, want, got);
		end
	endfunction

	// compare a taken report with the oldest expected report
	task automatic check_report();
		peak_report_t want;
		if (reports_due.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected report: index %h ratio %h dz %b ovf %b",
					peak_index, peak_ratio, divide_by_zero, overflow);
			return;
		end
		want = reports_due.pop_front();
		cmp_field("peak_index", want.pos, peak_index);
		cmp_field("peak_ratio", want.ratio, peak_ratio);
		cmp_field("divide_by_zero", want.dz, divide_by_zero);
		cmp_field("overflow", want.ovf, overflow);
		reports_seen++;
	endtask

	// result side: check taken words, random stall runs
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			check_report();
		if (rx_hold > 0) begin
			rx_hold = rx_hold - 1;
			out_stall <= 1'b1;
		end else begin
			rx_gap = pick_gap(stall_pct);
			if (rx_gap > 0) begin
				out_stall <= 1'b1;
				rx_hold = rx_gap - 1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// main sequence
	initial begin
		int i, ph, sent, len, k, mode, row_set, excl_set, phase_words, cap;
		peak_report_t none;
		none = '0;
		in_valid <= 1'b0;
		corr_value <= '0;
		last_item <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_ROW_LENGTH;
		cfg_data <= '0;
		arst_n <= 1'b0;
		mismatches = 0;
		reports_seen = 0;
		words_sent = 0;
		maps_sent = 0;
		settings_used = 1;
		idle_pct = 0;
		stall_pct = 0;
		top_value = '0;
		top_pos = 0;
		word_count = 0;
		map_dropped = 1'b0;
		row_cfg = ROW_LENGTH_RST;
		excl_cfg = EXCLUDE_WIDTH_RST;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed maps under the reset settings
		// single zero word: nothing to scan, divide by zero
		add_row(32'h0, 1'b1, 1'b1, 16'd0, 32'hFFFF_FFFF, 1'b1, 1'b0);
		// single full-scale word
		add_row(32'hFFFF_FFFF, 1'b1, 1'b1, 16'd0, 32'hFFFF_FFFF, 1'b1, 1'b0);
		// start position counts inside the window, ratio saturates
		add_row(32'd5, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0);
		add_row(32'hFFFF_FFFF, 1'b1, 1'b1, 16'd1, 32'hFFFF_FFFF, 1'b0, 1'b0);
		// tie: first occurrence is the peak, ratio exactly one
		add_row(32'hFFFF_FFFF, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0);
		add_row(32'hFFFF_FFFF, 1'b1, 1'b1, 16'd0, 32'h0001_0000, 1'b0, 1'b0);
		// all-zero map
		add_row(32'h0, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0);
		add_row(32'h0, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0);
		add_row(32'h0, 1'b1, 1'b1, 16'd0, 32'hFFFF_FFFF, 1'b1, 1'b0);
		// ramp with a peak, neighbors inside the window skipped
		add_row(32'd10, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0);
		add_row(32'd20, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0);
		add_row(32'd30, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0);
		add_row(32'd40, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0);
		add_row(32'd50, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0);
		add_row(32'd60, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0);
		add_row(32'd1000, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0);
		add_row(32'd70, 1'b1, 1'b0, '0, '0, 1'b0, 1'b0);
		// all other words excluded, only the start position left
		add_row(32'd7, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0);
		add_row(32'd3, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0);
		add_row(32'd9, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0);
		add_row(32'd9, 1'b1, 1'b0, '0, '0, 1'b0, 1'b0);
		// tiny second peak, saturated ratio
		add_row(32'd1, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0);
		add_row(32'h8000_0000, 1'b1, 1'b1, 16'd1, 32'hFFFF_FFFF, 1'b0, 1'b0);

		idle_pct = 20;
		stall_pct = 20;
		for (i = 0; i < dir_tab.size(); i++)
			push_word(dir_tab[i].value, dir_tab[i].last, dir_tab[i].typed, dir_tab[i].want);

		// random maps over a range of register settings
		for (ph = 0; ph < 10; ph++) begin
			case (ph)
				0: begin row_set = 2; excl_set = 0; idle_pct = 20; stall_pct = 20;
					phase_words = 120; end
				1: begin row_set = 0; excl_set = 1; idle_pct = 0; stall_pct = 0;
					phase_words = 100; end
				2: begin row_set = 1; excl_set = 16383; idle_pct = 30; stall_pct = 40;
					phase_words = 100; end
				3: begin row_set = $urandom_range(3, 24); excl_set = $urandom_range(0, 6);
					idle_pct = 20; stall_pct = 20; phase_words = 150; end
				4: begin row_set = $urandom_range(5, 40); excl_set = 2; idle_pct = 0;
					stall_pct = 0; phase_words = 150; end
				5: begin row_set = 16383; excl_set = 8192; idle_pct = 15; stall_pct = 15;
					phase_words = 60; end
				6: begin row_set = 8192; excl_set = 0; idle_pct = 10; stall_pct = 30;
					phase_words = 60; end
				7: begin row_set = $urandom_range(2, 16); excl_set = $urandom_range(0, 20);
					idle_pct = 10; stall_pct = 60; phase_words = 150; end
				8: begin row_set = $urandom_range(9, 64); excl_set = $urandom_range(0, 70);
					idle_pct = 40; stall_pct = 10; phase_words = 150; end
				default: begin row_set = $urandom_range(2, 8); excl_set = $urandom_range(0, 3);
					idle_pct = 25; stall_pct = 25; phase_words = 100; end
			endcase
			settle();
			load_settings(row_set, excl_set);
			sent = 0;
			while (sent < phase_words) begin
				cap = (active_row() * 3 < 40) ? active_row() * 3 : 40;
				len = $urandom_range(1, cap);
				mode = $urandom_range(0, 3);
				for (k = 0; k < len; k++)
					push_word(pick_value(mode), k == len - 1, 1'b0, none);
				sent += len;
			end
		end

		settle();
		$display("tb: %0d words in %0d maps, %0d reports checked, %0d register settings",
			words_sent, maps_sent, reports_seen, settings_used);
		$display("tb: covered short rows, clamped rows, wide windows, ties and saturated ratios");
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
